FILE: rtl/query_language_lexer_unit_macros.svh
// assertion macros shared by the rtl
`ifndef QUERY_LANGUAGE_LEXER_UNIT_MACROS_SVH
`define QUERY_LANGUAGE_LEXER_UNIT_MACROS_SVH

// plain property checked on every edge out of reset
`define QLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the same edge
`define QLL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication checked on the following edge
`define QLL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/qll_pkg.sv
`timescale 1ns / 1ps
package qll_pkg;

  localparam int OFFSET_W = 32;
  localparam int LINE_W   = 20;
  localparam int COL_W    = 16;
  localparam int KIND_W   = 5;
  localparam int MAX_TOK  = 4;
  localparam int FIFO_DEPTH = 8;

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_OP, M_DOLLAR, M_IDENT, M_INT, M_DOT, M_FRAC,
    M_EXP, M_EXPD, M_Q1, M_Q2, M_STR, M_STRQ, M_TRI
  } mode_t;

  localparam logic [KIND_W-1:0] K_ERR = 5'd0,  K_EOF = 5'd1,  K_STR = 5'd2,
    K_INT = 5'd3, K_FLOAT = 5'd4, K_IDENT = 5'd5, K_NE = 5'd6, K_LE = 5'd7,
    K_GE = 5'd8, K_PIPE = 5'd9, K_DOT = 5'd10, K_COLON = 5'd11, K_COMMA = 5'd12,
    K_LPAR = 5'd13, K_RPAR = 5'd14, K_LBRK = 5'd15, K_RBRK = 5'd16,
    K_LBRC = 5'd17, K_RBRC = 5'd18, K_AT = 5'd19, K_EQ = 5'd20, K_LT = 5'd21,
    K_GT = 5'd22, K_STAR = 5'd23, K_PLUS = 5'd24, K_MINUS = 5'd25,
    K_SLASH = 5'd26, K_PCT = 5'd27;

  localparam logic [7:0] CH_LF = 8'h0a, CH_TAB = 8'h09, CH_CR = 8'h0d,
    CH_SP = 8'h20, CH_HASH = 8'h23, CH_DOLLAR = 8'h24, CH_QUOTE = 8'h27,
    CH_MINUS = 8'h2d, CH_PLUS = 8'h2b, CH_BANG = 8'h21, CH_LT = 8'h3c,
    CH_GT = 8'h3e, CH_EQ = 8'h3d, CH_PIPE = 8'h7c, CH_DOT = 8'h2e,
    CH_US = 8'h5f, CH_LE = 8'h65, CH_UE = 8'h45;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [OFFSET_W-1:0] start;
    logic [OFFSET_W-1:0] len;
    logic [LINE_W-1:0]   line;
    logic [COL_W-1:0]    col;
    logic                last;
  } tok_t;

  typedef struct packed {
    logic [2:0]         cnt;
    tok_t [MAX_TOK-1:0] tok;
  } emit_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      8'h2e:   k = K_DOT;
      8'h3a:   k = K_COLON;
      8'h2c:   k = K_COMMA;
      8'h28:   k = K_LPAR;
      8'h29:   k = K_RPAR;
      8'h5b:   k = K_LBRK;
      8'h5d:   k = K_RBRK;
      8'h7b:   k = K_LBRC;
      8'h7d:   k = K_RBRC;
      8'h40:   k = K_AT;
      8'h3d:   k = K_EQ;
      8'h3c:   k = K_LT;
      8'h3e:   k = K_GT;
      8'h2a:   k = K_STAR;
      8'h2b:   k = K_PLUS;
      8'h2d:   k = K_MINUS;
      8'h2f:   k = K_SLASH;
      8'h25:   k = K_PCT;
      default: k = K_ERR;
    endcase
    return k;
  endfunction

  function automatic tok_t mk_tok(input logic [KIND_W-1:0] kind,
                                  input logic [OFFSET_W-1:0] start,
                                  input logic [OFFSET_W-1:0] len,
                                  input logic [LINE_W-1:0] line,
                                  input logic [COL_W-1:0] col,
                                  input logic last);
    tok_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.line  = line;
    t.col   = col;
    t.last  = last;
    return t;
  endfunction

endpackage

FILE: rtl/qll_lex.sv
`timescale 1ns / 1ps
module qll_lex (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        byte_value,
  input  logic              byte_valid,
  input  logic              end_of_text,
  output qll_pkg::emit_t    emit
);

  localparam logic [qll_pkg::OFFSET_W-1:0] ONE_OFF = {{(qll_pkg::OFFSET_W-1){1'b0}}, 1'b1};
  localparam logic [qll_pkg::LINE_W-1:0] ONE_LINE = {{(qll_pkg::LINE_W-1){1'b0}}, 1'b1};
  localparam logic [qll_pkg::COL_W-1:0] ONE_COL = {{(qll_pkg::COL_W-1){1'b0}}, 1'b1};

  qll_pkg::mode_t mode_r, mode_nxt;
  logic [qll_pkg::OFFSET_W-1:0] pos_r, pos_nxt, ts_r, ts_nxt;
  logic [qll_pkg::LINE_W-1:0] line_r, line_nxt, tl_r, tl_nxt;
  logic [qll_pkg::COL_W-1:0] col_r, col_nxt, tc_r, tc_nxt, dotc_r, dotc_nxt;
  logic [7:0] held_r, held_nxt;
  logic [1:0] qrun_r, qrun_nxt;

  always_comb begin
    qll_pkg::tok_t [qll_pkg::MAX_TOK-1:0] q;
    logic [2:0] n;
    logic [7:0] c;
    logic fall;
    logic [qll_pkg::OFFSET_W-1:0] nx;
    c = byte_value;
    q = '0;
    n = 3'd0;
    fall = 1'b0;
    mode_nxt = mode_r;
    pos_nxt = pos_r;
    line_nxt = line_r;
    col_nxt = col_r;
    ts_nxt = ts_r;
    tl_nxt = tl_r;
    tc_nxt = tc_r;
    dotc_nxt = dotc_r;
    held_nxt = held_r;
    qrun_nxt = qrun_r;
    nx = pos_r + ONE_OFF;
    if (byte_valid) begin
      case (mode_r)
        qll_pkg::M_COMMENT: begin
          if (c == qll_pkg::CH_LF) mode_nxt = qll_pkg::M_IDLE;
        end
        qll_pkg::M_OP: begin
          if (held_r == qll_pkg::CH_MINUS && c == qll_pkg::CH_MINUS) begin
            mode_nxt = qll_pkg::M_COMMENT;
          end else if (c == qll_pkg::CH_EQ && (held_r == qll_pkg::CH_BANG ||
                       held_r == qll_pkg::CH_LT || held_r == qll_pkg::CH_GT)) begin
            q[n[1:0]] = qll_pkg::mk_tok(held_r == qll_pkg::CH_BANG ? qll_pkg::K_NE :
                         (held_r == qll_pkg::CH_LT ? qll_pkg::K_LE : qll_pkg::K_GE),
                         ts_r, nx - ts_r, tl_r, tc_r, 1'b0);
            n = n + 3'd1;
            mode_nxt = qll_pkg::M_IDLE;
          end else if (held_r == qll_pkg::CH_PIPE && c == qll_pkg::CH_PIPE) begin
            q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_PIPE, ts_r, nx - ts_r, tl_r, tc_r, 1'b0);
            n = n + 3'd1;
            mode_nxt = qll_pkg::M_IDLE;
          end else begin
            q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::single_kind(held_r), ts_r, pos_r - ts_r,
                                        tl_r, tc_r, 1'b0);
            n = n + 3'd1;
            fall = 1'b1;
          end
        end
        qll_pkg::M_DOLLAR: begin
          if (qll_pkg::is_alpha(c) || c == qll_pkg::CH_US) mode_nxt = qll_pkg::M_IDENT;
          else begin
            q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_ERR, ts_r, pos_r - ts_r, tl_r, tc_r, 1'b0);
            n = n + 3'd1;
            fall = 1'b1;
          end
        end
        qll_pkg::M_IDENT: begin
          if (!(qll_pkg::is_alpha(c) || qll_pkg::is_digit(c) || c == qll_pkg::CH_US)) begin
            q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_IDENT, ts_r, pos_r - ts_r, tl_r, tc_r, 1'b0);
            n = n + 3'd1;
            fall = 1'b1;
          end
        end
        qll_pkg::M_INT: begin
          if (qll_pkg::is_digit(c)) begin
          end else if (c == qll_pkg::CH_DOT) begin
            dotc_nxt = col_r;
            mode_nxt = qll_pkg::M_DOT;
          end else if (c == qll_pkg::CH_LE || c == qll_pkg::CH_UE) begin
            mode_nxt = qll_pkg::M_EXP;
          end else begin
            q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_INT, ts_r, pos_r - ts_r, tl_r, tc_r, 1'b0);
            n = n + 3'd1;
            fall = 1'b1;
          end
        end
        qll_pkg::M_DOT: begin
          if (qll_pkg::is_digit(c)) mode_nxt = qll_pkg::M_FRAC;
          else begin
            q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_INT, ts_r, pos_r - ONE_OFF - ts_r,
                                        tl_r, tc_r, 1'b0);
            n = n + 3'd1;
            q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_DOT, pos_r - ONE_OFF, ONE_OFF,
                                        line_r, dotc_r, 1'b0);
            n = n + 3'd1;
            fall = 1'b1;
          end
        end
        qll_pkg::M_FRAC: begin
          if (qll_pkg::is_digit(c)) begin
          end else if (c == qll_pkg::CH_LE || c == qll_pkg::CH_UE) begin
            mode_nxt = qll_pkg::M_EXP;
          end else begin
            q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_FLOAT, ts_r, pos_r - ts_r, tl_r, tc_r, 1'b0);
            n = n + 3'd1;
            fall = 1'b1;
          end
        end
        qll_pkg::M_EXP: begin
          if (c == qll_pkg::CH_PLUS || c == qll_pkg::CH_MINUS || qll_pkg::is_digit(c)) begin
            mode_nxt = qll_pkg::M_EXPD;
          end else begin
            q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_FLOAT, ts_r, pos_r - ts_r, tl_r, tc_r, 1'b0);
            n = n + 3'd1;
            fall = 1'b1;
          end
        end
        qll_pkg::M_EXPD: begin
          if (!qll_pkg::is_digit(c)) begin
            q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_FLOAT, ts_r, pos_r - ts_r, tl_r, tc_r, 1'b0);
            n = n + 3'd1;
            fall = 1'b1;
          end
        end
        qll_pkg::M_Q1: begin
          mode_nxt = (c == qll_pkg::CH_QUOTE) ? qll_pkg::M_Q2 : qll_pkg::M_STR;
        end
        qll_pkg::M_Q2: begin
          if (c == qll_pkg::CH_QUOTE) begin
            mode_nxt = qll_pkg::M_TRI;
            qrun_nxt = 2'd0;
          end else begin
            q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_STR, ts_r, pos_r - ts_r, tl_r, tc_r, 1'b0);
            n = n + 3'd1;
            fall = 1'b1;
          end
        end
        qll_pkg::M_STR: begin
          if (c == qll_pkg::CH_QUOTE) mode_nxt = qll_pkg::M_STRQ;
        end
        qll_pkg::M_STRQ: begin
          if (c == qll_pkg::CH_QUOTE) mode_nxt = qll_pkg::M_STR;
          else begin
            q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_STR, ts_r, pos_r - ts_r, tl_r, tc_r, 1'b0);
            n = n + 3'd1;
            fall = 1'b1;
          end
        end
        qll_pkg::M_TRI: begin
          if (c != qll_pkg::CH_QUOTE) qrun_nxt = 2'd0;
          else if (qrun_r >= 2'd2) begin
            q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_STR, ts_r, nx - ts_r, tl_r, tc_r, 1'b0);
            n = n + 3'd1;
            qrun_nxt = 2'd0;
            mode_nxt = qll_pkg::M_IDLE;
          end else qrun_nxt = qrun_r + 2'd1;
        end
        default: fall = 1'b1;
      endcase
      // byte that ended a token, or arrived while idle, starts afresh
      if (fall) begin
        mode_nxt = qll_pkg::M_IDLE;
        if (c == qll_pkg::CH_SP || c == qll_pkg::CH_TAB || c == qll_pkg::CH_CR ||
            c == qll_pkg::CH_LF) begin
        end else if (c == qll_pkg::CH_HASH) begin
          mode_nxt = qll_pkg::M_COMMENT;
        end else if (c == qll_pkg::CH_MINUS || c == qll_pkg::CH_BANG || c == qll_pkg::CH_LT ||
                     c == qll_pkg::CH_GT || c == qll_pkg::CH_PIPE) begin
          ts_nxt = pos_r; tl_nxt = line_r; tc_nxt = col_r;
          held_nxt = c;
          mode_nxt = qll_pkg::M_OP;
        end else if (c == qll_pkg::CH_QUOTE) begin
          ts_nxt = pos_r; tl_nxt = line_r; tc_nxt = col_r;
          mode_nxt = qll_pkg::M_Q1;
        end else if (qll_pkg::is_digit(c)) begin
          ts_nxt = pos_r; tl_nxt = line_r; tc_nxt = col_r;
          mode_nxt = qll_pkg::M_INT;
        end else if (qll_pkg::is_alpha(c) || c == qll_pkg::CH_US) begin
          ts_nxt = pos_r; tl_nxt = line_r; tc_nxt = col_r;
          mode_nxt = qll_pkg::M_IDENT;
        end else if (c == qll_pkg::CH_DOLLAR) begin
          ts_nxt = pos_r; tl_nxt = line_r; tc_nxt = col_r;
          mode_nxt = qll_pkg::M_DOLLAR;
        end else begin
          q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::single_kind(c), pos_r, ONE_OFF,
                                      line_r, col_r, 1'b0);
          n = n + 3'd1;
        end
      end
      pos_nxt = nx;
      if (c == qll_pkg::CH_LF) begin
        if (line_r != '1) line_nxt = line_r + ONE_LINE;
        col_nxt = ONE_COL;
      end else if (col_r != '1) begin
        col_nxt = col_r + ONE_COL;
      end
    end
    if (end_of_text) begin
      case (mode_nxt)
        qll_pkg::M_OP: begin
          q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::single_kind(held_nxt), ts_nxt,
                                      pos_nxt - ts_nxt, tl_nxt, tc_nxt, 1'b0);
          n = n + 3'd1;
        end
        qll_pkg::M_DOLLAR, qll_pkg::M_Q1, qll_pkg::M_STR, qll_pkg::M_TRI: begin
          q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_ERR, ts_nxt, pos_nxt - ts_nxt,
                                      tl_nxt, tc_nxt, 1'b0);
          n = n + 3'd1;
        end
        qll_pkg::M_IDENT: begin
          q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_IDENT, ts_nxt, pos_nxt - ts_nxt,
                                      tl_nxt, tc_nxt, 1'b0);
          n = n + 3'd1;
        end
        qll_pkg::M_INT: begin
          q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_INT, ts_nxt, pos_nxt - ts_nxt,
                                      tl_nxt, tc_nxt, 1'b0);
          n = n + 3'd1;
        end
        qll_pkg::M_DOT: begin
          q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_INT, ts_nxt, pos_nxt - ONE_OFF - ts_nxt,
                                      tl_nxt, tc_nxt, 1'b0);
          n = n + 3'd1;
          q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_DOT, pos_nxt - ONE_OFF, ONE_OFF,
                                      line_nxt, dotc_nxt, 1'b0);
          n = n + 3'd1;
        end
        qll_pkg::M_FRAC, qll_pkg::M_EXP, qll_pkg::M_EXPD: begin
          q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_FLOAT, ts_nxt, pos_nxt - ts_nxt,
                                      tl_nxt, tc_nxt, 1'b0);
          n = n + 3'd1;
        end
        qll_pkg::M_Q2, qll_pkg::M_STRQ: begin
          q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_STR, ts_nxt, pos_nxt - ts_nxt,
                                      tl_nxt, tc_nxt, 1'b0);
          n = n + 3'd1;
        end
        default: begin
        end
      endcase
      q[n[1:0]] = qll_pkg::mk_tok(qll_pkg::K_EOF, pos_nxt, '0, line_nxt, col_nxt, 1'b1);
      n = n + 3'd1;
      mode_nxt = qll_pkg::M_IDLE;
      pos_nxt = '0; ts_nxt = '0;
      line_nxt = ONE_LINE; tl_nxt = ONE_LINE;
      col_nxt = ONE_COL; tc_nxt = ONE_COL; dotc_nxt = ONE_COL;
      held_nxt = '0; qrun_nxt = '0;
    end
    emit.cnt = n;
    emit.tok = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= qll_pkg::M_IDLE;
      pos_r  <= '0;
      ts_r   <= '0;
      line_r <= ONE_LINE;
      tl_r   <= ONE_LINE;
      col_r  <= ONE_COL;
      tc_r   <= ONE_COL;
      dotc_r <= ONE_COL;
      held_r <= '0;
      qrun_r <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      ts_r   <= ts_nxt;
      line_r <= line_nxt;
      tl_r   <= tl_nxt;
      col_r  <= col_nxt;
      tc_r   <= tc_nxt;
      dotc_r <= dotc_nxt;
      held_r <= held_nxt;
      qrun_r <= qrun_nxt;
    end
  end

endmodule

FILE: rtl/query_language_lexer_unit.sv
`timescale 1ns / 1ps
// Query language lexer. Text bytes come in on the in_ channel, one word per
// byte: in_tdata is the byte, in_tuser says it is present (0 gives an
// end-only word) and in_tlast marks the end of the text. Tokens leave on
// the out_ channel with the kind in out_tuser and out_tlast high on the
// eof token that closes each text.
// A byte is taken when in_tvalid and in_tready are both high; the lexer state
// and token decision update at that edge and the tokens it yields (up to four)
// are written into an eight-word output queue, whose head drives out_.
// Throughput is one byte per clock while the queue has room: in_tready
// is high whenever the queue has room for four more tokens, so one byte can
// follow another in the next cycle. A stalled receiver fills the queue and
// in_tready then drops until words drain; nothing is lost.
// Reset (rst_n low, synchronous) empties the queue and returns the lexer to
// line 1, column 1, offset 0. The same state is restored after every eof.
`include "query_language_lexer_unit_macros.svh"
module query_language_lexer_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // byte_value
  input  logic         in_tuser,   // byte_valid
  input  logic         in_tlast,   // end_of_text
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // start_offset, token_length, token_line, start_column, pad
  output logic [4:0]   out_tuser,  // token_kind
  output logic         out_tlast   // last_token
);

  localparam int AW = $clog2(qll_pkg::FIFO_DEPTH);

  qll_pkg::emit_t emit;
  qll_pkg::tok_t  mem [qll_pkg::FIFO_DEPTH];
  qll_pkg::tok_t  head;
  logic [AW-1:0]  wr_r, rd_r;
  logic [AW:0]    cnt_r;
  logic           in_acc, out_acc;

  assign in_tready = (cnt_r <= (AW+1)'(qll_pkg::FIFO_DEPTH - qll_pkg::MAX_TOK));
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  qll_lex u_lex (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (in_acc),
    .byte_value  (in_tdata),
    .byte_valid  (in_tuser),
    .end_of_text (in_tlast),
    .emit        (emit)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < qll_pkg::MAX_TOK; i++) begin
        if (3'(i) < emit.cnt) mem[wr_r + AW'(i)] <= emit.tok[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (in_acc) wr_r <= wr_r + AW'(emit.cnt);
      if (out_acc) rd_r <= rd_r + AW'(1);
      cnt_r <= cnt_r + (in_acc ? (AW+1)'(emit.cnt) : '0) - (AW+1)'(out_acc);
    end
  end

  assign head       = mem[rd_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;
  assign out_tdata  = {4'b0, head.col, head.line, head.len, head.start};

  `QLL_ASSERT(a_cnt_bound, cnt_r <= (AW+1)'(qll_pkg::FIFO_DEPTH), "output queue overfilled")
  `QLL_ASSERT_IMP(a_last_eof, out_tvalid && out_tlast, out_tuser == qll_pkg::K_EOF, "last word not eof")
  `QLL_ASSERT_IMP(a_eof_zero, out_tvalid && out_tlast, out_tdata[63:32] == '0, "eof with length")
  `QLL_ASSERT_NXT(a_idle_hold, !in_acc && !out_acc, $stable(cnt_r), "queue count moved while idle")

endmodule

FILE: dv/lexer_checker.sv
`timescale 1ns / 1ps
module lexer_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         in_tuser,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  input  logic [4:0]   out_tuser,
  input  logic         out_tlast,
  output int           errors,
  output int           pending
);
  import qll_pkg::*;

  tok_t token_q[$];

  mode_t         mode;
  logic [31:0]   pos, ts;
  logic [19:0]   line, tsl;
  logic [15:0]   col, tsc, dotc;
  logic [7:0]    held;
  logic [1:0]    qrun;

  assign pending = token_q.size();

  function automatic bit digit_c(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit letter_c(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic [4:0] op_kind(input logic [7:0] c);
    case (c)
      8'h2e: return K_DOT;    8'h3a: return K_COLON;  8'h2c: return K_COMMA;
      8'h28: return K_LPAR;   8'h29: return K_RPAR;   8'h5b: return K_LBRK;
      8'h5d: return K_RBRK;   8'h7b: return K_LBRC;   8'h7d: return K_RBRC;
      8'h40: return K_AT;     8'h3d: return K_EQ;     8'h3c: return K_LT;
      8'h3e: return K_GT;     8'h2a: return K_STAR;   8'h2b: return K_PLUS;
      8'h2d: return K_MINUS;  8'h2f: return K_SLASH;  8'h25: return K_PCT;
      default: return K_ERR;
    endcase
  endfunction

  task automatic push_tok(input logic [4:0] k, input logic [31:0] s, input logic [31:0] n,
                          input logic [19:0] l, input logic [15:0] c, input logic e);
    tok_t t;
    t.kind = k; t.start = s; t.len = n; t.line = l; t.col = c; t.last = e;
    token_q.push_back(t);
  endtask

  task automatic close_tok(input logic [4:0] k, input logic [31:0] end_at);
    push_tok(k, ts, end_at - ts, tsl, tsc, 1'b0);
  endtask

  task automatic int_then_dot();
    logic [31:0] dot_at;
    dot_at = pos - 32'd1;
    close_tok(K_INT, dot_at);
    push_tok(K_DOT, dot_at, 32'd1, line, dotc, 1'b0);
  endtask

  task automatic mark_start();
    ts = pos; tsl = line; tsc = col;
  endtask

  task automatic fresh_byte(input logic [7:0] c);
    mode = M_IDLE;
    if (c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF) return;
    if (c == CH_HASH) begin
      mode = M_COMMENT;
    end else if (c == CH_MINUS || c == CH_BANG || c == CH_LT || c == CH_GT
                 || c == CH_PIPE) begin
      mark_start(); held = c; mode = M_OP;
    end else if (c == CH_QUOTE) begin
      mark_start(); mode = M_Q1;
    end else if (digit_c(c)) begin
      mark_start(); mode = M_INT;
    end else if (letter_c(c) || c == CH_US) begin
      mark_start(); mode = M_IDENT;
    end else if (c == CH_DOLLAR) begin
      mark_start(); mode = M_DOLLAR;
    end else begin
      push_tok(op_kind(c), pos, 32'd1, line, col, 1'b0);
    end
  endtask

  task automatic lex_byte(input logic [7:0] c);
    logic [31:0] nxt;
    bit restart;
    nxt = pos + 32'd1;
    restart = 1;
    case (mode)
      M_COMMENT: begin
        if (c == CH_LF) mode = M_IDLE;
        restart = 0;
      end
      M_OP: begin
        if (held == CH_MINUS && c == CH_MINUS) begin
          mode = M_COMMENT; restart = 0;
        end else if (c == CH_EQ && (held == CH_BANG || held == CH_LT || held == CH_GT)) begin
          close_tok(held == CH_BANG ? K_NE : (held == CH_LT ? K_LE : K_GE), nxt);
          mode = M_IDLE; restart = 0;
        end else if (held == CH_PIPE && c == CH_PIPE) begin
          close_tok(K_PIPE, nxt); mode = M_IDLE; restart = 0;
        end else begin
          close_tok(op_kind(held), pos);
        end
      end
      M_DOLLAR: begin
        if (letter_c(c) || c == CH_US) begin
          mode = M_IDENT; restart = 0;
        end else close_tok(K_ERR, pos);
      end
      M_IDENT: begin
        if (letter_c(c) || digit_c(c) || c == CH_US) restart = 0;
        else close_tok(K_IDENT, pos);
      end
      M_INT: begin
        if (digit_c(c)) restart = 0;
        else if (c == CH_DOT) begin
          dotc = col; mode = M_DOT; restart = 0;
        end else if (c == CH_LE || c == CH_UE) begin
          mode = M_EXP; restart = 0;
        end else close_tok(K_INT, pos);
      end
      M_DOT: begin
        if (digit_c(c)) begin
          mode = M_FRAC; restart = 0;
        end else int_then_dot();
      end
      M_FRAC: begin
        if (digit_c(c)) restart = 0;
        else if (c == CH_LE || c == CH_UE) begin
          mode = M_EXP; restart = 0;
        end else close_tok(K_FLOAT, pos);
      end
      M_EXP: begin
        if (c == CH_PLUS || c == CH_MINUS || digit_c(c)) begin
          mode = M_EXPD; restart = 0;
        end else close_tok(K_FLOAT, pos);
      end
      M_EXPD: begin
        if (digit_c(c)) restart = 0;
        else close_tok(K_FLOAT, pos);
      end
      M_Q1: begin
        mode = (c == CH_QUOTE) ? M_Q2 : M_STR; restart = 0;
      end
      M_Q2: begin
        if (c == CH_QUOTE) begin
          mode = M_TRI; qrun = 2'd0; restart = 0;
        end else close_tok(K_STR, pos);
      end
      M_STR: begin
        if (c == CH_QUOTE) mode = M_STRQ;
        restart = 0;
      end
      M_STRQ: begin
        if (c == CH_QUOTE) begin
          mode = M_STR; restart = 0;
        end else close_tok(K_STR, pos);
      end
      M_TRI: begin
        restart = 0;
        if (c != CH_QUOTE) qrun = 2'd0;
        else if (qrun >= 2'd2) begin
          close_tok(K_STR, nxt); qrun = 2'd0; mode = M_IDLE;
        end else qrun = qrun + 2'd1;
      end
      default: ;
    endcase
    if (restart) fresh_byte(c);
  endtask

  task automatic clear_state();
    mode = M_IDLE; pos = 32'd0; line = 20'd1; col = 16'd1; ts = 32'd0; tsl = 20'd1;
    tsc = 16'd1; held = 8'd0; qrun = 2'd0; dotc = 16'd1;
  endtask

  task automatic end_text();
    case (mode)
      M_OP: close_tok(op_kind(held), pos);
      M_DOLLAR, M_Q1, M_STR, M_TRI: close_tok(K_ERR, pos);
      M_IDENT: close_tok(K_IDENT, pos);
      M_INT: close_tok(K_INT, pos);
      M_DOT: int_then_dot();
      M_FRAC, M_EXP, M_EXPD: close_tok(K_FLOAT, pos);
      M_Q2, M_STRQ: close_tok(K_STR, pos);
      default: ;
    endcase
    push_tok(K_EOF, pos, 32'd0, line, col, 1'b1);
    clear_state();
  endtask

  task automatic take_word(input logic [7:0] c, input logic v, input logic e);
    if (v) begin
      lex_byte(c);
      pos = pos + 32'd1;
      if (c == CH_LF) begin
        if (line != '1) line = line + 20'd1;
        col = 16'd1;
      end else if (col != '1) col = col + 16'd1;
    end
    if (e) end_text();
  endtask

  initial begin
    errors = 0;
    clear_state();
  end

  always @(posedge clk) begin
    tok_t x;
    if (rst_n) begin
      if (in_tvalid && in_tready) take_word(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        if (token_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected token kind %0d", out_tuser);
        end else begin
          x = token_q.pop_front();
          if (out_tuser !== x.kind || out_tdata[31:0] !== x.start
              || out_tdata[63:32] !== x.len || out_tdata[83:64] !== x.line
              || out_tdata[99:84] !== x.col || out_tlast !== x.last) begin
            errors++;
            if (errors <= 10)
              $display({"token mismatch exp k%0d s%0d n%0d l%0d c%0d e%0d",
                        " got k%0d s%0d n%0d l%0d c%0d e%0d"},
                       x.kind, x.start, x.len, x.line, x.col, x.last, out_tuser,
                       out_tdata[31:0], out_tdata[63:32], out_tdata[83:64],
                       out_tdata[99:84], out_tlast);
          end
        end
      end
    end
  end
endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [7:0]   in_tdata = 0;
  logic         in_tuser = 0;
  logic         in_tlast = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [103:0] out_tdata;
  logic [4:0]   out_tuser;
  logic         out_tlast;
  int           errors, pending;
  int           sent = 0;
  bit           calm = 0;
  bit           drained = 0;
  int           stall_left = 0;

  string frags[] = '{"abc", "_q9", "$x_1", "$1", "$", "123", "4.75", "1.", "2e", "3E+4",
    "7e-", "6.2e19", "'ab''c'", "''", "'''x'y''''", "'''", "'open", "#note\n",
    "--dash\n", "-", "!=", "<=", ">=", "||", "!", "|", "<", ">", "x.y", ".", ":", ",",
    "(", ")", "[", "]", "{", "}", "@", "=", "*", "+", "/", "%", " ", "\t", "\r\n", "\n"};

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  query_language_lexer_unit uut (.*);

  lexer_checker chk (.*);

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1;
    end else if (stall_left == 0) begin
      stall_left <= $urandom_range(1, 15);
      out_tready <= $urandom_range(0, 2) != 0;
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  task automatic idle_gap(input int n);
    in_tvalid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic put_word(input logic [7:0] b, input logic v, input logic e);
    if (!calm && $urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 15));
    in_tvalid <= 1;
    in_tdata <= b;
    in_tuser <= v;
    in_tlast <= e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (v || e) sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_word(s[i], 1'b1, i == s.len() - 1);
  endtask

  task automatic random_text();
    string s;
    int n;
    s = "";
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) s = {s, string'(8'($urandom_range(0, 255)))};
      else s = {s, frags[$urandom_range(0, frags.size() - 1)]};
      if ($urandom_range(0, 2) == 0) s = {s, " "};
    end
    for (int i = 0; i < s.len(); i++) begin
      if ($urandom_range(0, 30) == 0) put_word(8'($urandom), 1'b0, 1'b0);
      put_word(s[i], 1'b1, 1'b0);
    end
    // end marker either rides on a byte or comes as its own word
    if ($urandom_range(0, 1)) put_word(8'($urandom), 1'b0, 1'b1);
    else put_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    put_text("''");
    put_text("1.");
    put_text("'ab");
    put_text("'''x");
    put_word(8'hff, 1'b1, 1'b0);
    put_word(8'h00, 1'b1, 1'b1);
    put_word(8'h55, 1'b0, 1'b0);
    put_word(8'haa, 1'b0, 1'b1);
    put_text("9e");
    put_text("$");
    while (sent < 330) begin
      if (sent > 280) calm = 1;
      random_text();
      if (!drained && sent > 150) begin
        drained = 1;
        idle_gap(1);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
      end
    end
    in_tvalid <= 0;
    calm = 1;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
